@@ design/hget_pkg.sv @@
`default_nettype none

package hget_pkg;

    localparam int STORE_BYTES_DEF = 2048;
    localparam int FILL_W          = 12;
    localparam int PAT_W           = 14;
    localparam logic [FILL_W-1:0] FILL_MAX = 12'd4095;
    localparam logic [10:0]       MAX_HDR_RESET = 11'd1500;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [3:0] {
        ST_INCOMPLETE = 4'd0,
        ST_OK         = 4'd1,
        ST_EXCEEDED   = 4'd2,
        ST_NOT_GET    = 4'd3,
        ST_LINE_SHORT = 4'd4,
        ST_NO_VERSION = 4'd5,
        ST_URI_SEP    = 4'd6,
        ST_NOT_HTTP   = 4'd7,
        ST_NOT_200    = 4'd8,
        ST_NO_LENGTH  = 4'd9,
        ST_NO_DIGITS  = 4'd10,
        ST_BODY       = 4'd11
    } t_code;

    typedef enum logic [1:0] {
        PH_REQUEST  = 2'd0,
        PH_RESPONSE = 2'd1,
        PH_BODY     = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        PAT_TERM, PAT_CRLF, PAT_VERSION, PAT_GET, PAT_HTTP, PAT_OK, PAT_CLEN
    } t_pat;

    typedef enum logic [2:0] {
        MODE_SEQ, MODE_SPACE, MODE_NONSPACE, MODE_DIGIT, MODE_NUMBER
    } t_mode;

    typedef enum logic [2:0] {
        FROM_ZERO, FROM_THREE, FROM_FOUR, FROM_POS, FROM_POS_P1, FROM_POS_M8
    } t_from;

    typedef enum logic [1:0] {
        LIM_FILL, LIM_THREE, LIM_FOUR
    } t_lim;

    typedef struct packed {
        logic   accept;
        logic   scan_start;
        t_mode  mode;
        t_pat   pat;
        t_from  from;
        t_lim   lim;
        logic   save_term;
        logic   fin_resp;
        logic   clear_fill;
        logic   phase_wr;
        t_phase phase_val;
        logic   out_load;
        t_code  out_code;
        logic   out_hdr;
    } t_cmd;

    typedef struct packed {
        t_phase phase;
        logic   fill_ge4;
        logic   over;
        logic   rem_zero;
        logic   scan_done;
        logic   scan_found;
        logic   pos_lt8;
        logic   out_full;
    } t_stat;

    // Pattern bytes packed with the last character in the lowest byte.
    function automatic logic [PAT_W*8-1:0] pat_bytes(input t_pat id);
        logic [PAT_W*8-1:0] v;
        v = '0;
        unique case (id)
            PAT_TERM:    v = (PAT_W*8)'({CH_CR, CH_LF, CH_CR, CH_LF});
            PAT_CRLF:    v = (PAT_W*8)'({CH_CR, CH_LF});
            PAT_VERSION: v = (PAT_W*8)'("HTTP/");
            PAT_GET:     v = (PAT_W*8)'("GET");
            PAT_HTTP:    v = (PAT_W*8)'("HTTP");
            PAT_OK:      v = (PAT_W*8)'({"200 OK", CH_CR, CH_LF});
            PAT_CLEN:    v = (PAT_W*8)'("Content-Length");
            default:     v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] pat_len(input t_pat id);
        logic [3:0] n;
        n = 4'd1;
        unique case (id)
            PAT_TERM:    n = 4'd4;
            PAT_CRLF:    n = 4'd2;
            PAT_VERSION: n = 4'd5;
            PAT_GET:     n = 4'd3;
            PAT_HTTP:    n = 4'd4;
            PAT_OK:      n = 4'd8;
            PAT_CLEN:    n = 4'd14;
            default:     n = 4'd1;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

@@ design/hget_ram.sv @@
`default_nettype none

module hget_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/hget_ctrl.sv @@
`default_nettype none

module hget_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_last,
    output logic                o_in_ready,
    input  wire hget_pkg::t_stat i_stat,
    output hget_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_EVAL, S_TERM, S_GET, S_CRLF, S_VERSION, S_SP1, S_NSP, S_SP2,
        S_HTTP, S_OK, S_CLEN, S_DIG1, S_DIGS, S_OUT
    } t_state;

    t_state          r_state, n_state;
    hget_pkg::t_code r_code, n_code;
    logic            r_hdr, n_hdr;

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        n_hdr   = r_hdr;
        o_cmd            = '0;
        o_cmd.mode       = hget_pkg::MODE_SEQ;
        o_cmd.pat        = hget_pkg::PAT_TERM;
        o_cmd.from       = hget_pkg::FROM_ZERO;
        o_cmd.lim        = hget_pkg::LIM_FILL;
        o_cmd.phase_val  = hget_pkg::PH_REQUEST;
        o_cmd.out_code   = r_code;
        o_cmd.out_hdr    = r_hdr;
        o_in_ready       = 1'b0;

        unique case (r_state) inside
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                n_hdr        = 1'b0;
                if (i_in_valid && i_in_last) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.phase == hget_pkg::PH_BODY) begin
                    n_code = hget_pkg::ST_BODY;
                    if (i_stat.rem_zero) begin
                        o_cmd.phase_wr = 1'b1;
                    end
                    n_state = S_OUT;
                end else if (!i_stat.fill_ge4) begin
                    n_code  = hget_pkg::ST_INCOMPLETE;
                    n_state = S_OUT;
                end else if (i_stat.over) begin
                    n_code           = hget_pkg::ST_EXCEEDED;
                    o_cmd.phase_wr   = 1'b1;
                    o_cmd.clear_fill = 1'b1;
                    n_state          = S_OUT;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_TERM;
                end
            end
            S_TERM: begin
                if (i_stat.scan_done) begin
                    if (!i_stat.scan_found) begin
                        n_code  = hget_pkg::ST_INCOMPLETE;
                        n_state = S_OUT;
                    end else begin
                        o_cmd.save_term  = 1'b1;
                        o_cmd.scan_start = 1'b1;
                        if (i_stat.phase == hget_pkg::PH_REQUEST) begin
                            o_cmd.pat = hget_pkg::PAT_GET;
                            o_cmd.lim = hget_pkg::LIM_THREE;
                            n_state   = S_GET;
                        end else begin
                            o_cmd.pat = hget_pkg::PAT_HTTP;
                            o_cmd.lim = hget_pkg::LIM_FOUR;
                            n_state   = S_HTTP;
                        end
                    end
                end
            end
            S_GET: begin
                if (i_stat.scan_done) begin
                    if (!i_stat.scan_found) begin
                        n_code = hget_pkg::ST_NOT_GET;
                        n_state = S_OUT;
                        o_cmd.clear_fill = 1'b1;
                        o_cmd.phase_wr   = 1'b1;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.pat        = hget_pkg::PAT_CRLF;
                        n_state          = S_CRLF;
                    end
                end
            end
            S_CRLF: begin
                if (i_stat.scan_done) begin
                    if (!i_stat.scan_found || i_stat.pos_lt8) begin
                        n_code = hget_pkg::ST_LINE_SHORT;
                        n_state = S_OUT;
                        o_cmd.clear_fill = 1'b1;
                        o_cmd.phase_wr   = 1'b1;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.pat        = hget_pkg::PAT_VERSION;
                        o_cmd.from       = hget_pkg::FROM_POS_M8;
                        n_state          = S_VERSION;
                    end
                end
            end
            S_VERSION: begin
                if (i_stat.scan_done) begin
                    if (!i_stat.scan_found) begin
                        n_code = hget_pkg::ST_NO_VERSION;
                        n_state = S_OUT;
                        o_cmd.clear_fill = 1'b1;
                        o_cmd.phase_wr   = 1'b1;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.mode       = hget_pkg::MODE_SPACE;
                        o_cmd.from       = hget_pkg::FROM_THREE;
                        n_state          = S_SP1;
                    end
                end
            end
            S_SP1, S_NSP, S_SP2: begin
                if (i_stat.scan_done) begin
                    if (!i_stat.scan_found) begin
                        n_code = hget_pkg::ST_URI_SEP;
                        n_state = S_OUT;
                        o_cmd.clear_fill = 1'b1;
                        o_cmd.phase_wr   = 1'b1;
                    end else if (r_state == S_SP1) begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.mode       = hget_pkg::MODE_NONSPACE;
                        o_cmd.from       = hget_pkg::FROM_POS_P1;
                        n_state          = S_NSP;
                    end else if (r_state == S_NSP) begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.mode       = hget_pkg::MODE_SPACE;
                        o_cmd.from       = hget_pkg::FROM_POS;
                        n_state          = S_SP2;
                    end else begin
                        n_code           = hget_pkg::ST_OK;
                        o_cmd.clear_fill = 1'b1;
                        o_cmd.phase_wr   = 1'b1;
                        o_cmd.phase_val  = hget_pkg::PH_RESPONSE;
                        n_state          = S_OUT;
                    end
                end
            end
            S_HTTP: begin
                if (i_stat.scan_done) begin
                    if (!i_stat.scan_found) begin
                        n_code = hget_pkg::ST_NOT_HTTP;
                        n_state = S_OUT;
                        o_cmd.clear_fill = 1'b1;
                        o_cmd.phase_wr   = 1'b1;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.pat        = hget_pkg::PAT_OK;
                        o_cmd.from       = hget_pkg::FROM_FOUR;
                        n_state          = S_OK;
                    end
                end
            end
            S_OK: begin
                if (i_stat.scan_done) begin
                    if (!i_stat.scan_found) begin
                        n_code = hget_pkg::ST_NOT_200;
                        n_state = S_OUT;
                        o_cmd.clear_fill = 1'b1;
                        o_cmd.phase_wr   = 1'b1;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.pat        = hget_pkg::PAT_CLEN;
                        o_cmd.from       = hget_pkg::FROM_POS;
                        n_state          = S_CLEN;
                    end
                end
            end
            S_CLEN: begin
                if (i_stat.scan_done) begin
                    if (!i_stat.scan_found) begin
                        n_code = hget_pkg::ST_NO_LENGTH;
                        n_state = S_OUT;
                        o_cmd.clear_fill = 1'b1;
                        o_cmd.phase_wr   = 1'b1;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.mode       = hget_pkg::MODE_DIGIT;
                        o_cmd.from       = hget_pkg::FROM_POS;
                        n_state          = S_DIG1;
                    end
                end
            end
            S_DIG1: begin
                if (i_stat.scan_done) begin
                    if (!i_stat.scan_found) begin
                        n_code = hget_pkg::ST_NO_DIGITS;
                        n_state = S_OUT;
                        o_cmd.clear_fill = 1'b1;
                        o_cmd.phase_wr   = 1'b1;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.mode       = hget_pkg::MODE_NUMBER;
                        o_cmd.from       = hget_pkg::FROM_POS;
                        n_state          = S_DIGS;
                    end
                end
            end
            S_DIGS: begin
                if (i_stat.scan_done) begin
                    n_code           = hget_pkg::ST_OK;
                    n_hdr            = 1'b1;
                    o_cmd.fin_resp   = 1'b1;
                    o_cmd.clear_fill = 1'b1;
                    n_state          = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stat.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= hget_pkg::ST_INCOMPLETE;
            r_hdr   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
            r_hdr   <= n_hdr;
        end
    end

endmodule

`default_nettype wire

@@ design/hget_dp.sv @@
`default_nettype none

module hget_dp #(
    parameter int STORE_BYTES = hget_pkg::STORE_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire hget_pkg::t_cmd i_cmd,
    output hget_pkg::t_stat     o_stat,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_byte_present,
    input  wire logic           i_cfg_wr_en,
    input  wire logic [10:0]    i_cfg_wr_data,
    input  wire logic           i_out_ready,
    output logic                o_out_valid,
    output logic [3:0]          o_status,
    output logic [1:0]          o_new_phase,
    output logic [31:0]         o_content_remaining,
    output logic [10:0]         o_header_bytes,
    output logic [15:0]         o_body_bytes
);

    localparam int AW = $clog2(STORE_BYTES);
    localparam int FW = hget_pkg::FILL_W;
    localparam int PW = hget_pkg::PAT_W;
    localparam logic [32:0] LEN_SAT = 33'h1_0000_0000;

    logic [10:0]         r_max;
    hget_pkg::t_phase    r_phase, n_phase;
    logic [FW-1:0]       r_fill, n_fill;
    logic [32:0]         r_rem, n_rem;
    logic [15:0]         r_seg, n_seg;
    logic [FW-1:0]       r_term;

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic                r_found, n_found;
    logic [FW-1:0]       r_pos, n_pos;
    hget_pkg::t_mode     r_mode, n_mode;
    hget_pkg::t_pat      r_pat, n_pat;
    logic [FW-1:0]       r_rd, n_rd;
    logic [FW-1:0]       r_lim, n_lim;
    logic                r_pv, n_pv;
    logic [FW-1:0]       r_pq, n_pq;
    logic [7:0]          r_win [PW];
    logic [7:0]          n_win [PW];
    logic [3:0]          r_wcnt, n_wcnt;
    logic [32:0]         r_v, n_v;

    logic                wr_en;
    logic                rd_en;
    logic [7:0]          rd_data;
    logic [7:0]          win_new [PW];
    logic [3:0]          cnt_new;
    logic [3:0]          plen;
    logic [PW*8-1:0]     pbytes;
    logic                seq_hit;
    logic                is_dig;
    logic                hit;
    logic [FW-1:0]       hit_pos;
    logic [36:0]         v10;
    logic [FW-1:0]       from_val;
    logic [FW-1:0]       lim_val;
    logic [FW-1:0]       body_cnt;
    logic [32:0]         fin_rem;

    assign wr_en = i_cmd.accept && i_byte_present && (r_phase != hget_pkg::PH_BODY)
                   && (32'(r_fill) < STORE_BYTES);

    hget_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(r_fill)),
        .i_wr_data (i_data_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (AW'(r_rd)),
        .o_rd_data (rd_data)
    );

    always_comb begin
        plen    = hget_pkg::pat_len(r_pat);
        pbytes  = hget_pkg::pat_bytes(r_pat);
        cnt_new = (r_wcnt == 4'(PW)) ? r_wcnt : r_wcnt + 4'd1;
        win_new[0] = rd_data;
        for (int k = 1; k < PW; k++) begin
            win_new[k] = r_win[k-1];
        end
        seq_hit = (cnt_new >= plen);
        for (int k = 0; k < PW; k++) begin
            if ((4'(k) < plen) && (win_new[k] != pbytes[k*8 +: 8])) begin
                seq_hit = 1'b0;
            end
        end
        is_dig = (rd_data >= 8'h30) && (rd_data <= 8'h39);
        v10 = ({4'b0, r_v} << 3) + ({4'b0, r_v} << 1) + 37'(rd_data[3:0]);

        case (i_cmd.from)
            hget_pkg::FROM_THREE:  from_val = FW'(3);
            hget_pkg::FROM_FOUR:   from_val = FW'(4);
            hget_pkg::FROM_POS:    from_val = r_pos;
            hget_pkg::FROM_POS_P1: from_val = r_pos + FW'(1);
            hget_pkg::FROM_POS_M8: from_val = r_pos - FW'(8);
            default:               from_val = '0;
        endcase
        case (i_cmd.lim)
            hget_pkg::LIM_THREE: lim_val = FW'(3);
            hget_pkg::LIM_FOUR:  lim_val = FW'(4);
            default:             lim_val = r_fill;
        endcase

        body_cnt = r_fill - (r_term + FW'(4));
        fin_rem  = (r_v > 33'(body_cnt)) ? r_v - 33'(body_cnt) : '0;
    end

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_found = r_found;
        n_pos   = r_pos;
        n_mode  = r_mode;
        n_pat   = r_pat;
        n_rd    = r_rd;
        n_lim   = r_lim;
        n_pv    = r_pv;
        n_pq    = r_pq;
        n_win   = r_win;
        n_wcnt  = r_wcnt;
        n_v     = r_v;
        rd_en   = 1'b0;
        hit     = 1'b0;
        hit_pos = r_pq;

        if (i_cmd.scan_start) begin
            n_busy = 1'b1;
            n_mode = i_cmd.mode;
            n_pat  = i_cmd.pat;
            n_rd   = from_val;
            n_lim  = lim_val;
            n_pv   = 1'b0;
            n_wcnt = '0;
            n_v    = '0;
        end else if (r_busy) begin
            if (r_pv) begin
                case (r_mode)
                    hget_pkg::MODE_SEQ: begin
                        n_win   = win_new;
                        n_wcnt  = cnt_new;
                        hit     = seq_hit;
                        hit_pos = r_pq - FW'(plen) + FW'(1);
                    end
                    hget_pkg::MODE_SPACE:    hit = (rd_data == hget_pkg::CH_SPACE);
                    hget_pkg::MODE_NONSPACE: hit = (rd_data != hget_pkg::CH_SPACE);
                    hget_pkg::MODE_DIGIT:    hit = is_dig;
                    default: begin
                        if (is_dig) begin
                            n_v = (v10 > 37'(LEN_SAT)) ? LEN_SAT : v10[32:0];
                        end else begin
                            hit = 1'b1;
                        end
                    end
                endcase
            end
            if (hit) begin
                n_busy  = 1'b0;
                n_done  = 1'b1;
                n_found = 1'b1;
                n_pos   = hit_pos;
                n_pv    = 1'b0;
            end else if (r_rd < r_lim) begin
                rd_en = 1'b1;
                n_rd  = r_rd + FW'(1);
                n_pv  = 1'b1;
                n_pq  = r_rd;
            end else begin
                n_busy  = 1'b0;
                n_done  = 1'b1;
                n_found = 1'b0;
                n_pv    = 1'b0;
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_fill  = r_fill;
        n_rem   = r_rem;
        n_seg   = r_seg;
        if (i_cmd.accept && i_byte_present) begin
            if (r_phase == hget_pkg::PH_BODY) begin
                if (r_rem != '0) begin
                    n_rem = r_rem - 33'd1;
                end
                if (r_seg != 16'hffff) begin
                    n_seg = r_seg + 16'd1;
                end
            end else if (r_fill != hget_pkg::FILL_MAX) begin
                n_fill = r_fill + FW'(1);
            end
        end
        if (i_cmd.phase_wr) begin
            n_phase = i_cmd.phase_val;
        end
        if (i_cmd.fin_resp) begin
            n_seg = 16'(body_cnt);
            if (body_cnt != '0) begin
                n_rem   = fin_rem;
                n_phase = (fin_rem == '0) ? hget_pkg::PH_REQUEST : hget_pkg::PH_BODY;
            end else begin
                n_rem   = r_v;
                n_phase = hget_pkg::PH_BODY;
            end
        end
        if (i_cmd.clear_fill) begin
            n_fill = '0;
        end
        if (i_cmd.out_load) begin
            n_seg = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= hget_pkg::MAX_HDR_RESET;
            r_phase     <= hget_pkg::PH_REQUEST;
            r_fill      <= '0;
            r_rem       <= '0;
            r_seg       <= '0;
            r_busy      <= 1'b0;
            r_done      <= 1'b0;
            r_pv        <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max <= i_cfg_wr_data;
            end
            r_phase <= n_phase;
            r_fill  <= n_fill;
            r_rem   <= n_rem;
            r_seg   <= n_seg;
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_pv    <= n_pv;
            if (i_cmd.out_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_found <= n_found;
        r_pos   <= n_pos;
        r_mode  <= n_mode;
        r_pat   <= n_pat;
        r_rd    <= n_rd;
        r_lim   <= n_lim;
        r_pq    <= n_pq;
        r_win   <= n_win;
        r_wcnt  <= n_wcnt;
        r_v     <= n_v;
        if (i_cmd.save_term) begin
            r_term <= r_pos;
        end
        if (i_cmd.out_load) begin
            o_status            <= i_cmd.out_code;
            o_new_phase         <= r_phase;
            o_content_remaining <= r_rem[32] ? 32'hffff_ffff : r_rem[31:0];
            o_header_bytes      <= i_cmd.out_hdr ? 11'(r_term + FW'(4)) : 11'd0;
            o_body_bytes        <= r_seg;
        end
    end

    always_comb begin
        o_stat.phase      = r_phase;
        o_stat.fill_ge4   = (r_fill >= FW'(4));
        o_stat.over       = (r_fill > FW'(r_max)) || (32'(r_fill) > STORE_BYTES);
        o_stat.rem_zero   = (r_rem == '0);
        o_stat.scan_done  = r_done;
        o_stat.scan_found = r_found;
        o_stat.pos_lt8    = (r_pos < FW'(8));
        o_stat.out_full   = o_out_valid;
    end

endmodule

`default_nettype wire

@@ design/http_get_exchange_tracker_core.sv @@
// Channel     Direction  Payload
// s_axis      in         tdata[7:0] data_byte, tuser byte_present, tlast segment_end
// m_axis      out        tdata status, new_phase, content_remaining, header_bytes,
//                        body_bytes (zero filled to 72 bits)
// cfg         in         wr_data[10:0] max_header_bytes
//
// An item without a segment end is taken in the idle state. A segment end in the
// body phase passes only the evaluation and output states; in a header phase it
// takes the scans of the header store, one byte per cycle through the store's read
// port, up to seven passes of at most the stored length each.
// Reset is synchronous and active low; the store needs no clearing. A held
// output item does not block input until the next segment end must be reported.
`default_nettype none

module http_get_exchange_tracker_core #(
    parameter int STORE_BYTES = hget_pkg::STORE_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    input  wire logic        s_axis_tuser,   // byte_present
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status[3:0], new_phase[5:4], content_remaining[37:6], header_bytes[48:38],
    // body_bytes[64:49], zeros above
    output logic [71:0]      m_axis_tdata,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [10:0] i_cfg_wr_data
);

    hget_pkg::t_cmd  cmd;
    hget_pkg::t_stat stat;
    logic [3:0]      out_status;
    logic [1:0]      out_phase;
    logic [31:0]     out_rem;
    logic [10:0]     out_hdr;
    logic [15:0]     out_body;

    hget_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hget_dp #(
        .STORE_BYTES (STORE_BYTES)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_data_byte         (s_axis_tdata),
        .i_byte_present      (s_axis_tuser),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_out_ready         (m_axis_tready),
        .o_out_valid         (m_axis_tvalid),
        .o_status            (out_status),
        .o_new_phase         (out_phase),
        .o_content_remaining (out_rem),
        .o_header_bytes      (out_hdr),
        .o_body_bytes        (out_body)
    );

    assign m_axis_tdata = {7'd0, out_body, out_hdr, out_rem, out_phase, out_status};

`ifndef ASSERT_OFF
    a_end_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken while a segment end is being evaluated");

    a_scan_not_during_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.accept && (cmd.scan_start || stat.scan_done)))
        else $error("store scan overlaps an input item");

    a_hdr_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[3:0] != hget_pkg::ST_OK) |-> m_axis_tdata[48:38] == 11'd0)
        else $error("header length reported without an accepted response");

    a_phase_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[5:4] != 2'd3)
        else $error("unused phase code reported");
`endif

endmodule

`default_nettype wire
